// ===== sv/sliding_window_extreme_filter_macros.svh =====
// Assertion macros for the sliding window extreme filter.
`ifndef SLIDING_WINDOW_EXTREME_FILTER_MACROS_SVH
`define SLIDING_WINDOW_EXTREME_FILTER_MACROS_SVH

`ifndef SYNTH

`define SWEF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swef check failed");

`define SWEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swef check failed");

`else

`define SWEF_ASSERT_IMP(label, clk, rst, ante, cons)

`define SWEF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/swef_pkg.sv =====
package swef_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int POS_BITS         = 16;
  localparam int WINDOW_SIZE_BITS = 7;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 7;

  localparam logic [WINDOW_SIZE_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_FIND_MINIMUM = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CMP,
    ST_BACK_RD,
    ST_BACK_CMP,
    ST_PUSH,
    ST_RES_RD,
    ST_RES
  } state_t;

  typedef struct packed {
    logic idle;
    logic accept;
    logic front_rd;
    logic drop_front;
    logic back_rd;
    logic drop_back;
    logic push;
    logic res_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic count_zero;
    logic front_expired;
    logic back_drop;
    logic result_due;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/swef_sample_if.sv =====
interface swef_sample_if #(
  parameter int SAMPLE_BITS = swef_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_sequence;

  modport source (output valid, output sample, output start_sequence, input ready);
  modport sink (input valid, input sample, input start_sequence, output ready);
endinterface

// ===== sv/swef_result_if.sv =====
interface swef_result_if #(
  parameter int SAMPLE_BITS = swef_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_extreme;

  modport source (output valid, output window_extreme, input ready);
  modport sink (input valid, input window_extreme, output ready);
endinterface

// ===== sv/swef_ctrl.sv =====
module swef_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  swef_pkg::sts_t sts,
  output swef_pkg::cmd_t cmd
);

  swef_pkg::state_t state;
  swef_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swef_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      swef_pkg::ST_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.accept = 1'b1;
          state_next = swef_pkg::ST_FRONT_RD;
        end
      end
      swef_pkg::ST_FRONT_RD: begin
        if (sts.count_zero) begin
          state_next = swef_pkg::ST_PUSH;
        end else begin
          cmd.front_rd = 1'b1;
          state_next   = swef_pkg::ST_FRONT_CMP;
        end
      end
      swef_pkg::ST_FRONT_CMP: begin
        if (sts.front_expired) begin
          cmd.drop_front = 1'b1;
          state_next     = swef_pkg::ST_FRONT_RD;
        end else begin
          state_next = swef_pkg::ST_BACK_RD;
        end
      end
      swef_pkg::ST_BACK_RD: begin
        if (sts.count_zero) begin
          state_next = swef_pkg::ST_PUSH;
        end else begin
          cmd.back_rd = 1'b1;
          state_next  = swef_pkg::ST_BACK_CMP;
        end
      end
      swef_pkg::ST_BACK_CMP: begin
        if (sts.back_drop) begin
          cmd.drop_back = 1'b1;
          state_next    = swef_pkg::ST_BACK_RD;
        end else begin
          state_next = swef_pkg::ST_PUSH;
        end
      end
      swef_pkg::ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = sts.result_due ? swef_pkg::ST_RES_RD : swef_pkg::ST_IDLE;
      end
      swef_pkg::ST_RES_RD: begin
        cmd.res_rd = 1'b1;
        state_next = swef_pkg::ST_RES;
      end
      swef_pkg::ST_RES: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = swef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swef_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swef_dp.sv =====
`include "sliding_window_extreme_filter_macros.svh"

module swef_dp #(
  parameter int WINDOW_MAX  = swef_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swef_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swef_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [swef_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  swef_sample_if.sink                         samples,
  swef_result_if.source                       results,
  input  swef_pkg::cmd_t                      cmd,
  output swef_pkg::sts_t                      sts
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = CW + 1;
  localparam int PW = swef_pkg::POS_BITS;
  localparam int WB = swef_pkg::WINDOW_SIZE_BITS;
  localparam int KW = (CW > WB) ? CW : WB;

  logic signed [SAMPLE_BITS-1:0] mem_val [WINDOW_MAX];
  logic [PW-1:0]                 mem_pos [WINDOW_MAX];

  logic [WB-1:0]                 window_size;
  logic                          find_minimum;
  logic [AW-1:0]                 head;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 seen;
  logic [PW-1:0]                 sample_position;
  logic                          out_valid;

  logic signed [SAMPLE_BITS-1:0] s_reg;
  logic [PW-1:0]                 pos_reg;
  logic [CW-1:0]                 k_reg;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic [PW-1:0]                 rd_pos;
  logic signed [SAMPLE_BITS-1:0] out_val;

  logic [KW-1:0]                 ws_ext;
  logic [CW-1:0]                 k_new;
  logic [AW-1:0]                 head_inc;
  logic [SW-1:0]                 sum_tail;
  logic [SW-1:0]                 sum_back;
  logic [AW-1:0]                 tail_addr;
  logic [AW-1:0]                 back_addr;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_en;
  logic                          full;
  logic [PW-1:0]                 age;
  logic [SW-1:0]                 seen_inc;
  logic [CW-1:0]                 seen_next;

  assign ws_ext = KW'(window_size);

  always_comb begin
    if (window_size == '0) begin
      k_new = CW'(1);
    end else if (ws_ext > KW'(WINDOW_MAX)) begin
      k_new = CW'(WINDOW_MAX);
    end else begin
      k_new = CW'(ws_ext);
    end
  end

  assign head_inc  = (head == AW'(WINDOW_MAX - 1)) ? '0 : head + AW'(1);
  assign sum_tail  = SW'(head) + SW'(count);
  assign sum_back  = sum_tail - SW'(1);
  assign tail_addr = (sum_tail >= SW'(WINDOW_MAX)) ? AW'(sum_tail - SW'(WINDOW_MAX))
                                                   : AW'(sum_tail);
  assign back_addr = (sum_back >= SW'(WINDOW_MAX)) ? AW'(sum_back - SW'(WINDOW_MAX))
                                                   : AW'(sum_back);
  assign full      = (count == CW'(WINDOW_MAX));
  assign wr_addr   = full ? head : tail_addr;
  assign rd_en     = cmd.front_rd | cmd.back_rd | cmd.res_rd;
  assign rd_addr   = cmd.back_rd ? back_addr : head;

  assign age       = pos_reg - rd_pos;
  assign seen_inc  = SW'(seen) + SW'(1);
  assign seen_next = (seen_inc > SW'(k_reg)) ? k_reg : CW'(seen_inc);

  assign sts.in_valid      = samples.valid;
  assign sts.count_zero    = (count == '0);
  assign sts.front_expired = (age >= PW'(k_reg));
  assign sts.back_drop     = find_minimum ? (rd_val > s_reg) : (rd_val < s_reg);
  assign sts.result_due    = (seen_inc >= SW'(k_reg));
  assign sts.out_free      = !out_valid || results.ready;

  assign samples.ready          = cmd.idle;
  assign results.valid          = out_valid;
  assign results.window_extreme = out_val;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_val[wr_addr] <= s_reg;
      mem_pos[wr_addr] <= pos_reg;
    end
    if (rd_en) begin
      rd_val <= mem_val[rd_addr];
      rd_pos <= mem_pos[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_reg   <= samples.sample;
      pos_reg <= samples.start_sequence ? '0 : sample_position;
      k_reg   <= k_new;
    end
    if (cmd.load_out) begin
      out_val <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size     <= swef_pkg::WINDOW_SIZE_RESET;
      find_minimum    <= 1'b0;
      head            <= '0;
      count           <= '0;
      seen            <= '0;
      sample_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swef_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_wdata[WB-1:0];
          swef_pkg::REG_FIND_MINIMUM: find_minimum <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept && samples.start_sequence) begin
        head  <= '0;
        count <= '0;
        seen  <= '0;
      end
      if (cmd.drop_front) begin
        head  <= head_inc;
        count <= count - CW'(1);
      end
      if (cmd.drop_back) begin
        count <= count - CW'(1);
      end
      if (cmd.push) begin
        if (full) begin
          head <= head_inc;
        end else begin
          count <= count + CW'(1);
        end
        sample_position <= pos_reg + PW'(1);
        seen            <= seen_next;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SWEF_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(WINDOW_MAX))
  `SWEF_ASSERT_IMP(a_pop_nonempty, clk, rst, cmd.drop_front || cmd.drop_back, count != '0)
  `SWEF_ASSERT_NEXT(a_push_fills, clk, rst, cmd.push, count != '0)
  `SWEF_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, !out_valid || results.ready)

endmodule

// ===== sv/sliding_window_extreme_filter.sv =====
// Channel   Dir  Payload                        Beat when
// samples   in   sample, start_sequence         samples.valid && samples.ready
// results   out  window_extreme                 results.valid && results.ready
// cfg       in   cfg_index, cfg_wdata           cfg_we
//
// Each sample is accepted in idle and then read against the deque through the one read
// port of the deque memory: expired entries are dropped at the front and entries that
// the new sample beats are dropped at the back, each end stopping on a kept entry or an
// empty deque. The sample is then pushed, and a due result is read and loaded out.
// Reset (rst, synchronous) empties the deque and loads the register defaults.
// A result waits in the output register; loading the next one stalls until it is taken.
module sliding_window_extreme_filter #(
  parameter int WINDOW_MAX  = swef_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swef_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swef_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [swef_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  swef_sample_if.sink                         samples,
  swef_result_if.source                       results
);

  swef_pkg::cmd_t cmd;
  swef_pkg::sts_t sts;

  swef_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  swef_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (samples),
    .results   (results),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
